[rtl/led_strand_serial_sequencer_top_defines.svh]
// assertion macros for the led strand serial sequencer
// used by the top level only; expects clk and arst_n in scope
`ifndef LED_STRAND_SERIAL_SEQUENCER_TOP_DEFINES_SVH
`define LED_STRAND_SERIAL_SEQUENCER_TOP_DEFINES_SVH

// same-cycle implication
`define LSSS_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("lsss assertion failed");

// next-cycle implication
`define LSSS_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("lsss assertion failed");

`endif

[rtl/lsss_pkg.sv]
// shared types and constants for the led strand serial sequencer
// no dependencies
package lsss_pkg;

	localparam int MAX_PIXELS     = 64;
	localparam int PIX_AW         = 6;
	localparam int CNT_W          = 7;
	localparam int HEADER_BITS    = 32;
	localparam int BITS_PER_PIXEL = 16;
	localparam int TOP_BIT        = 15;
	localparam int QDEPTH         = 4;
	localparam int QAW            = 2;
	localparam int QCW            = 3;

	localparam logic [15:0] BLACK       = 16'h8000;
	localparam logic [CNT_W-1:0] PIXEL_COUNT_RST = 7'd64;

	// item operations
	localparam logic [1:0] OP_TICK  = 2'd0;
	localparam logic [1:0] OP_WRITE = 2'd1;
	localparam logic [1:0] OP_SHOW  = 2'd2;
	localparam logic [1:0] OP_SWAP  = 2'd3;

	// sequencer phases
	localparam logic [1:0] PH_DONE   = 2'd0;
	localparam logic [1:0] PH_HEADER = 2'd1;
	localparam logic [1:0] PH_DATA   = 2'd2;
	localparam logic [1:0] PH_START  = 2'd3;

	// how the data line moves when an item reaches the second stage
	localparam logic [1:0] LVL_KEEP = 2'd0;
	localparam logic [1:0] LVL_ZERO = 2'd1;
	localparam logic [1:0] LVL_MEM  = 2'd2;

	typedef struct packed {
		logic       vld;
		logic [1:0] lvl_sel;
		logic [3:0] bit_sel;
		logic       clk_pulse;
		logic [1:0] phase;
	} stage_t;

	typedef struct packed {
		logic              rd_en;
		logic [PIX_AW-1:0] rd_addr;
		logic              wr_en;
		logic [PIX_AW-1:0] wr_addr;
		logic [15:0]       wr_data;
	} mem_req_t;

	typedef struct packed {
		logic       data_bit;
		logic       clock_pulse;
		logic       ready_res;
		logic [1:0] phase;
	} result_t;

endpackage

[rtl/led_strand_serial_sequencer_top.sv]
// led strand serial sequencer: one word in, one result word out; each word passes
// the pixel store read stage (stage_s1), then the result queue head
// throughput one word per cycle while the result queue has room; the sequencer updates in the accept cycle and the
// data line level follows in the next cycle from the pixel store read port
// reset: start phase, counters and flags clear, pixel count 64, store reads black
// through per-entry valid bits, so there is no clearing pass
module led_strand_serial_sequencer_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  op,
	input  logic [5:0]  pixel_index,
	input  logic [14:0] color_word,
	input  logic        swap_arm,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        data_bit,
	output logic        clock_pulse,
	output logic        ready_res,
	output logic [1:0]  phase,
	input  logic        cfg_we,
	input  logic [6:0]  cfg_wdata
);

	`include "led_strand_serial_sequencer_top_defines.svh"

	logic                        accept;
	lsss_pkg::stage_t            stage;
	lsss_pkg::stage_t            stage_s1;
	lsss_pkg::mem_req_t          mem_req;
	logic [15:0]                 rdata;
	logic                        line_level_q;
	logic                        level_n;
	lsss_pkg::result_t           res;
	lsss_pkg::result_t           head;
	logic [lsss_pkg::QCW-1:0]    q_count;
	logic [lsss_pkg::QCW-1:0]    q_reserved;
	logic                        pop;

	// reserve a queue slot for the word in the read stage
	assign q_reserved = q_count + {{(lsss_pkg::QCW-1){1'b0}}, stage_s1.vld};
	assign in_ready   = q_reserved < lsss_pkg::QCW'(lsss_pkg::QDEPTH);
	assign accept     = in_valid && in_ready;

	lsss_seq_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (accept),
		.op          (op),
		.pixel_index (pixel_index),
		.color_word  (color_word),
		.swap_arm    (swap_arm),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.stage       (stage),
		.mem_req     (mem_req)
	);

	lsss_pixel_store u_store (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mem_req),
		.rdata  (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stage_s1 <= '0;
		end else begin
			stage_s1 <= stage;
		end
	end

	always_comb begin
		level_n = line_level_q;
		if (stage_s1.vld) begin
			unique case (stage_s1.lvl_sel)
				lsss_pkg::LVL_KEEP: level_n = line_level_q;
				lsss_pkg::LVL_ZERO: level_n = 1'b0;
				lsss_pkg::LVL_MEM:  level_n = rdata[stage_s1.bit_sel];
				default:            level_n = line_level_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_level_q <= 1'b0;
		end else begin
			line_level_q <= level_n;
		end
	end

	always_comb begin
		res.data_bit    = level_n;
		res.clock_pulse = stage_s1.clk_pulse;
		res.ready_res   = stage_s1.phase == lsss_pkg::PH_DONE;
		res.phase       = stage_s1.phase;
	end

	assign pop = out_valid && out_ready;

	lsss_out_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (stage_s1.vld),
		.push_data (res),
		.pop       (pop),
		.not_empty (out_valid),
		.head      (head),
		.count     (q_count)
	);

	assign data_bit    = head.data_bit;
	assign clock_pulse = head.clock_pulse;
	assign ready_res   = head.ready_res;
	assign phase       = head.phase;

	`LSSS_ASSERT_NEXT(a_accept_reaches_s1, accept, stage_s1.vld)
	`LSSS_ASSERT_NOW(a_s1_has_room, stage_s1.vld, q_count < lsss_pkg::QCW'(lsss_pkg::QDEPTH))
	`LSSS_ASSERT_NOW(a_ready_matches_phase, out_valid, ready_res == (phase == lsss_pkg::PH_DONE))

endmodule

[rtl/lsss_pixel_store.sv]
// pixel store: 64 x 16 synchronous memory with a registered read port
// entries never written read as black through per-entry valid bits; uses lsss_pkg
module lsss_pixel_store (
	input  logic                clk,
	input  logic                arst_n,
	input  lsss_pkg::mem_req_t  req,
	output logic [15:0]         rdata
);

	logic [15:0]                     mem [lsss_pkg::MAX_PIXELS];
	logic [lsss_pkg::MAX_PIXELS-1:0] written_q;
	logic [15:0]                     rdata_s1;
	logic                            rvld_s1;

	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem[req.wr_addr] <= req.wr_data;
		end
		if (req.rd_en) begin
			rdata_s1 <= mem[req.rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			written_q <= '0;
			rvld_s1   <= 1'b0;
		end else begin
			if (req.wr_en) begin
				written_q[req.wr_addr] <= 1'b1;
			end
			if (req.rd_en) begin
				rvld_s1 <= written_q[req.rd_addr];
			end
		end
	end

	assign rdata = rvld_s1 ? rdata_s1 : lsss_pkg::BLACK;

endmodule

[rtl/lsss_seq_ctrl.sv]
// frame sequencer control: phase, bit and pixel counters, pwm counter, swap flag
// issues pixel store reads and writes; uses lsss_pkg
module lsss_seq_ctrl (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          accept,
	input  logic [1:0]                    op,
	input  logic [lsss_pkg::PIX_AW-1:0]   pixel_index,
	input  logic [14:0]                   color_word,
	input  logic                          swap_arm,
	input  logic                          cfg_we,
	input  logic [lsss_pkg::CNT_W-1:0]    cfg_wdata,
	output lsss_pkg::stage_t              stage,
	output lsss_pkg::mem_req_t            mem_req
);

	logic [1:0]                 state_q, state_n;
	logic [5:0]                 bit_cnt_q, bit_cnt_n, bit_inc;
	logic [lsss_pkg::CNT_W-1:0] led_pos_q, led_pos_n, led_inc;
	logic [7:0]                 pwm_q, pwm_n;
	logic                       swap_q, swap_n;
	logic [lsss_pkg::CNT_W-1:0] pixel_count_q;
	logic [lsss_pkg::CNT_W-1:0] active;
	logic [1:0]                 lvl_sel;
	logic                       rd_en;

	// count in use: saturated to the store depth, zero treated as one
	always_comb begin
		if (pixel_count_q > lsss_pkg::CNT_W'(lsss_pkg::MAX_PIXELS)) begin
			active = lsss_pkg::CNT_W'(lsss_pkg::MAX_PIXELS);
		end else if (pixel_count_q == '0) begin
			active = lsss_pkg::CNT_W'(1);
		end else begin
			active = pixel_count_q;
		end
	end

	assign bit_inc = bit_cnt_q + 6'd1;
	assign led_inc = led_pos_q + lsss_pkg::CNT_W'(1);

	always_comb begin
		state_n   = state_q;
		bit_cnt_n = bit_cnt_q;
		led_pos_n = led_pos_q;
		pwm_n     = pwm_q;
		swap_n    = swap_q;
		lvl_sel   = lsss_pkg::LVL_KEEP;
		rd_en     = 1'b0;
		if (accept) begin
			unique case (op)
				lsss_pkg::OP_TICK: begin
					pwm_n = pwm_q + 8'd1;
					unique case (state_q)
						lsss_pkg::PH_DONE: begin
							if (swap_q && pwm_q == 8'd0) begin
								bit_cnt_n = '0;
								led_pos_n = '0;
								state_n   = lsss_pkg::PH_HEADER;
								swap_n    = 1'b0;
							end
						end
						lsss_pkg::PH_DATA: begin
							rd_en     = 1'b1;
							lvl_sel   = lsss_pkg::LVL_MEM;
							bit_cnt_n = bit_inc;
							if (bit_inc == 6'(lsss_pkg::BITS_PER_PIXEL)) begin
								led_pos_n = led_inc;
								if (led_inc < active) begin
									bit_cnt_n = '0;
								end else begin
									// end of frame drives the line low
									lvl_sel = lsss_pkg::LVL_ZERO;
									state_n = lsss_pkg::PH_DONE;
								end
							end
						end
						lsss_pkg::PH_HEADER: begin
							lvl_sel   = lsss_pkg::LVL_ZERO;
							bit_cnt_n = bit_inc;
							if (bit_inc >= 6'(lsss_pkg::HEADER_BITS)) begin
								state_n   = lsss_pkg::PH_DATA;
								led_pos_n = '0;
								bit_cnt_n = '0;
							end
						end
						lsss_pkg::PH_START: begin
							if (pwm_q == 8'd0) begin
								bit_cnt_n = '0;
								led_pos_n = '0;
								state_n   = lsss_pkg::PH_HEADER;
							end
						end
						default: begin
							state_n = state_q;
						end
					endcase
				end
				lsss_pkg::OP_WRITE: begin
					state_n = state_q;
				end
				lsss_pkg::OP_SHOW: begin
					bit_cnt_n = '0;
					led_pos_n = '0;
					pwm_n     = '0;
					state_n   = lsss_pkg::PH_START;
				end
				lsss_pkg::OP_SWAP: begin
					swap_n = swap_arm;
				end
				default: begin
					state_n = state_q;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= lsss_pkg::PH_START;
			bit_cnt_q     <= '0;
			led_pos_q     <= '0;
			pwm_q         <= '0;
			swap_q        <= 1'b0;
			pixel_count_q <= lsss_pkg::PIXEL_COUNT_RST;
		end else begin
			state_q   <= state_n;
			bit_cnt_q <= bit_cnt_n;
			led_pos_q <= led_pos_n;
			pwm_q     <= pwm_n;
			swap_q    <= swap_n;
			if (cfg_we) begin
				pixel_count_q <= cfg_wdata;
			end
		end
	end

	always_comb begin
		mem_req.rd_en = rd_en;
		if (led_pos_q < lsss_pkg::CNT_W'(lsss_pkg::MAX_PIXELS)) begin
			mem_req.rd_addr = led_pos_q[lsss_pkg::PIX_AW-1:0];
		end else begin
			mem_req.rd_addr = '0;
		end
		mem_req.wr_en   = accept && op == lsss_pkg::OP_WRITE
			&& {1'b0, pixel_index} < active;
		mem_req.wr_addr = pixel_index;
		mem_req.wr_data = {1'b1, color_word};
	end

	always_comb begin
		stage.vld       = accept;
		stage.lvl_sel   = lvl_sel;
		// msb first: bit 15 - (count mod 16)
		stage.bit_sel   = 4'(lsss_pkg::TOP_BIT) - bit_cnt_q[3:0];
		stage.clk_pulse = op == lsss_pkg::OP_TICK;
		stage.phase     = state_n;
	end

endmodule

[rtl/lsss_out_queue.sv]
// four-word result queue between the sequencer and the output channel
// reports its fill so the input side can reserve room; uses lsss_pkg
module lsss_out_queue (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         push,
	input  lsss_pkg::result_t            push_data,
	input  logic                         pop,
	output logic                         not_empty,
	output lsss_pkg::result_t            head,
	output logic [lsss_pkg::QCW-1:0]     count
);

	lsss_pkg::result_t           entries_q [lsss_pkg::QDEPTH];
	logic [lsss_pkg::QAW-1:0]    wr_ptr_q, rd_ptr_q;
	logic [lsss_pkg::QCW-1:0]    count_q;

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + lsss_pkg::QAW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + lsss_pkg::QAW'(1);
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + lsss_pkg::QCW'(1);
				2'b01:   count_q <= count_q - lsss_pkg::QCW'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	assign not_empty = count_q != '0;
	assign head      = entries_q[rd_ptr_q];
	assign count     = count_q;

endmodule

[test/testbench.sv]
// self-checking testbench for led_strand_serial_sequencer_top: random and directed words,
// a word-level predictor of the strand sequencer and a result scoreboard
// depends on lsss_pkg and the rtl top level only
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import lsss_pkg::*;

	localparam int STALL_LIMIT = 2000;
	localparam int LONG_FRAME  = 300;

	typedef struct packed {
		logic [1:0]  op;
		logic [5:0]  idx;
		logic [14:0] color;
		logic        arm;
	} strand_word_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [1:0]  op = OP_TICK;
	logic [5:0]  pixel_index = '0;
	logic [14:0] color_word = '0;
	logic        swap_arm = 1'b0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic        data_bit;
	logic        clock_pulse;
	logic        ready_res;
	logic [1:0]  phase;
	logic        cfg_we = 1'b0;
	logic [6:0]  cfg_wdata = '0;

	led_strand_serial_sequencer_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.op(op),
		.pixel_index(pixel_index),
		.color_word(color_word),
		.swap_arm(swap_arm),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.data_bit(data_bit),
		.clock_pulse(clock_pulse),
		.ready_res(ready_res),
		.phase(phase),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// mirror of the sequencer state
	logic [6:0]  strand_len = PIXEL_COUNT_RST;
	logic [1:0]  strand_phase = PH_START;
	logic [5:0]  bits_sent = '0;
	logic [6:0]  pixel_pos = '0;
	logic [7:0]  pwm_count = '0;
	logic        strand_line = 1'b0;
	logic        swap_armed = 1'b0;
	logic [15:0] pixel_mirror [0:MAX_PIXELS-1];

	strand_word_t pending_words[$];
	result_t      expected_outputs[$];
	int           words_left = 0;
	int           mismatches = 0;
	int           gen_items = 0;
	int           gen_pwm = 0;

	initial begin
		for (int i = 0; i < MAX_PIXELS; i++) pixel_mirror[i] = BLACK;
	end

	function automatic int used_len();
		int n;
		n = strand_len;
		if (n > MAX_PIXELS) n = MAX_PIXELS;
		if (n == 0) n = 1;
		return n;
	endfunction

	task step_tick();
		logic [5:0] p;
		logic [3:0] sel;
		case (strand_phase)
			PH_DONE: begin
				if (swap_armed && pwm_count == 8'd0) begin
					bits_sent = '0;
					pixel_pos = '0;
					strand_phase = PH_HEADER;
					swap_armed = 1'b0;
				end
			end
			PH_DATA: begin
				p = (pixel_pos < 7'd64) ? pixel_pos[5:0] : 6'd0;
				sel = 4'(TOP_BIT) - bits_sent[3:0];
				strand_line = pixel_mirror[p][sel];
				bits_sent = bits_sent + 6'd1;
				if (bits_sent == 6'(BITS_PER_PIXEL)) begin
					pixel_pos = pixel_pos + 7'd1;
					if (int'(pixel_pos) < used_len()) begin
						bits_sent = '0;
					end else begin
						// end of frame pulls the line low
						strand_line = 1'b0;
						strand_phase = PH_DONE;
					end
				end
			end
			PH_HEADER: begin
				strand_line = 1'b0;
				bits_sent = bits_sent + 6'd1;
				if (bits_sent >= 6'(HEADER_BITS)) begin
					strand_phase = PH_DATA;
					pixel_pos = '0;
					bits_sent = '0;
				end
			end
			default: begin
				if (pwm_count == 8'd0) begin
					bits_sent = '0;
					pixel_pos = '0;
					strand_phase = PH_HEADER;
				end
			end
		endcase
		pwm_count = pwm_count + 8'd1;
	endtask

	task predict_word(input strand_word_t w);
		result_t r;
		case (w.op)
			OP_TICK: step_tick();
			OP_WRITE: begin
				if (int'(w.idx) < used_len()) pixel_mirror[w.idx] = {1'b1, w.color};
			end
			OP_SHOW: begin
				bits_sent = '0;
				pixel_pos = '0;
				pwm_count = '0;
				strand_phase = PH_START;
			end
			default: swap_armed = w.arm;
		endcase
		r.data_bit = strand_line;
		r.clock_pulse = (w.op == OP_TICK);
		r.ready_res = (strand_phase == PH_DONE);
		r.phase = strand_phase;
		expected_outputs.push_back(r);
	endtask

	task report_mismatch(input string what, input int exp_v, input int got_v);
		$display("mismatch on %s at %0t: expected %0d, got %0d", what, $realtime, exp_v, got_v);
		mismatches++;
	endtask

	// driver: presents queued words, random gap after each one, none during calm stretches
	int send_wait = 0;
	int send_calm = 0;
	strand_word_t cur_word;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			send_wait = 0;
		end else begin
			if (in_valid && in_ready) begin
				predict_word(cur_word);
				words_left--;
			end
			if (!in_valid || in_ready) begin
				if (send_wait > 0) begin
					send_wait--;
					in_valid <= 1'b0;
				end else if (pending_words.size() > 0) begin
					cur_word = pending_words.pop_front();
					op <= cur_word.op;
					pixel_index <= cur_word.idx;
					color_word <= cur_word.color;
					swap_arm <= cur_word.arm;
					in_valid <= 1'b1;
					if (send_calm > 0) send_calm--;
					else if ($urandom_range(0, 40) == 0) send_calm = $urandom_range(20, 60);
					send_wait = (send_calm > 0) ? 0 : $urandom_range(0, 3);
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// monitor: checks each result word against the oldest expectation
	int recv_wait = 0;
	int recv_calm = 0;
	result_t exp_r;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			recv_wait = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_outputs.size() == 0) begin
					report_mismatch("result word with nothing expected", -1, phase);
				end else begin
					exp_r = expected_outputs.pop_front();
					if (data_bit !== exp_r.data_bit)
						report_mismatch("data_bit", exp_r.data_bit, data_bit);
					if (clock_pulse !== exp_r.clock_pulse)
						report_mismatch("clock_pulse", exp_r.clock_pulse, clock_pulse);
					if (ready_res !== exp_r.ready_res)
						report_mismatch("ready_res", exp_r.ready_res, ready_res);
					if (phase !== exp_r.phase)
						report_mismatch("phase", exp_r.phase, phase);
				end
				if (recv_calm > 0) recv_calm--;
				else if ($urandom_range(0, 40) == 0) recv_calm = $urandom_range(20, 60);
				recv_wait = (recv_calm > 0) ? 0 : $urandom_range(0, 3);
				if (recv_wait > 0) out_ready <= 1'b0;
			end else if (!out_ready) begin
				if (recv_wait == 0) out_ready <= 1'b1;
				else recv_wait--;
			end
		end
	end

	// watchdog on cycles with no word moving on either side
	int quiet_cycles = 0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quiet_cycles = 0;
		end else begin
			if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
			else quiet_cycles++;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("timeout: no word accepted for %0d cycles", STALL_LIMIT);
				$display("== FAIL ==");
				$finish;
			end
		end
	end

	// stimulus generation
	task push_word(input logic [1:0] o, input logic [5:0] i, input logic [14:0] c, input logic a);
		strand_word_t w;
		w.op = o;
		w.idx = i;
		w.color = c;
		w.arm = a;
		pending_words.push_back(w);
		words_left++;
		gen_items++;
		if (o == OP_TICK) gen_pwm = (gen_pwm + 1) % 256;
		else if (o == OP_SHOW) gen_pwm = 0;
	endtask

	function automatic logic [14:0] pick_color();
		case ($urandom_range(0, 3))
			0: return 15'h0000;
			1: return 15'h7fff;
			default: return 15'($urandom_range(0, 32767));
		endcase
	endfunction

	task push_ticks(input int k);
		for (int j = 0; j < k; j++)
			push_word(OP_TICK, 6'($urandom_range(0, 63)), pick_color(), 1'($urandom_range(0, 1)));
	endtask

	task push_noise();
		push_word(2'($urandom_range(0, 3)), 6'($urandom_range(0, 63)), pick_color(),
			1'($urandom_range(0, 1)));
	endtask

	// pixel writes, show, then ticks (through the whole frame if full) with an odd stray word mixed in
	task gen_frame(input bit full);
		int n;
		int nw;
		int ticks;
		n = used_len();
		nw = $urandom_range(0, 6);
		for (int j = 0; j < nw; j++)
			push_word(OP_WRITE,
				6'(($urandom_range(0, 7) == 0) ? $urandom_range(0, 63) : $urandom_range(0, n - 1)),
				pick_color(), 1'($urandom_range(0, 1)));
		push_word(OP_SHOW, 6'($urandom_range(0, 63)), pick_color(), 1'($urandom_range(0, 1)));
		ticks = full ? 33 + BITS_PER_PIXEL * n : $urandom_range(40, 200);
		for (int j = 0; j < ticks; j++) begin
			if ($urandom_range(0, 24) == 0) push_noise();
			push_ticks(1);
		end
		push_ticks($urandom_range(0, 5));
	endtask

	// full frame, then a swap request and ticks until the pwm counter wraps, then ticks for the swapped frame
	task gen_swap();
		int n;
		n = used_len();
		gen_frame(1'b1);
		push_word(OP_SWAP, 6'($urandom_range(0, 63)), pick_color(), ($urandom_range(0, 3) != 0));
		push_ticks((256 - gen_pwm) % 256 + 1);
		push_ticks(32 + BITS_PER_PIXEL * n + $urandom_range(0, 3));
	endtask

	task gen_phase(input int budget);
		int first;
		int f_len;
		int r;
		first = gen_items;
		f_len = 33 + BITS_PER_PIXEL * used_len();
		while (gen_items - first < budget) begin
			r = $urandom_range(0, 9);
			if (r < 6) begin
				gen_frame(f_len <= LONG_FRAME);
			end else if (r == 6 && f_len <= LONG_FRAME) begin
				gen_swap();
			end else begin
				r = $urandom_range(3, 15);
				for (int j = 0; j < r; j++) push_noise();
			end
		end
	endtask

	task wait_idle();
		while (words_left != 0 || expected_outputs.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task set_strand_len(input logic [6:0] v);
		wait_idle();
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		strand_len = v;
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: first tick out of reset, store extremes, ignored writes, swap both ways
		set_strand_len(7'd4);
		push_word(OP_TICK, 6'd0, 15'h0000, 1'b0);
		push_word(OP_WRITE, 6'd0, 15'h7fff, 1'b1);
		push_word(OP_WRITE, 6'd1, 15'h0000, 1'b0);
		push_word(OP_WRITE, 6'd3, 15'h2aaa, 1'b0);
		push_word(OP_WRITE, 6'd2, 15'h5555, 1'b1);
		push_word(OP_WRITE, 6'd4, 15'h1234, 1'b0);
		push_word(OP_WRITE, 6'd63, 15'h7fff, 1'b1);
		push_word(OP_SWAP, 6'd63, 15'h7fff, 1'b1);
		push_word(OP_SWAP, 6'd0, 15'h0000, 1'b0);
		push_word(OP_SHOW, 6'd63, 15'h7fff, 1'b1);
		push_ticks(14);

		set_strand_len(7'd1);
		gen_swap();
		gen_phase(100);
		// zero length behaves as one pixel
		set_strand_len(7'd0);
		gen_phase(80);
		set_strand_len(7'd2);
		gen_phase(80);
		set_strand_len(7'd3);
		gen_phase(80);
		set_strand_len(7'd65);
		gen_phase(60);

		// oversized length, saturated to the store depth
		set_strand_len(7'd127);
		for (int j = 0; j < 8; j++)
			push_word(OP_WRITE, 6'($urandom_range(0, 63)), pick_color(), 1'($urandom_range(0, 1)));
		push_word(OP_WRITE, 6'd63, pick_color(), 1'b0);
		gen_phase(40);

		set_strand_len(7'($urandom_range(1, 8)));
		gen_phase(60);

		wait_idle();
		repeat (4) @(posedge clk);
		if (mismatches == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
